@@ design/srr_pkg.sv @@
// Shared types and constants for the secant root refinement unit.
`timescale 1ns / 1ps
`default_nettype none
package srr_pkg;
	localparam int unsigned DW = 48;
	localparam int unsigned TOL_W = 25;
	localparam int unsigned STEPS_W = 11;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_X4 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X3 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd5;

	localparam logic [DW-1:0] TOL_RESET = 48'd168;

	typedef enum logic [1:0] {
		ST_EXACT = 2'd0,
		ST_TOL = 2'd1,
		ST_ZERO_DEN = 2'd2,
		ST_LIMIT = 2'd3
	} srr_status_t;

	// Datapath operations requested by the controller.
	typedef enum logic [3:0] {
		OP_LOAD = 4'd0,
		OP_POLY_X1 = 4'd1,
		OP_POLY_X2 = 4'd2,
		OP_POLY_X3 = 4'd3,
		OP_DEN = 4'd4,
		OP_DIV = 4'd5,
		OP_X3 = 4'd6,
		OP_SHIFT = 4'd7,
		OP_NONE = 4'd8
	} srr_op_t;

	typedef struct packed {
		logic start;
		srr_op_t op;
	} srr_cmd_t;

	typedef struct packed {
		logic done;
		logic den_zero;
		logic f3_zero;
		logic within_tol;
	} srr_stat_t;
endpackage
`default_nettype wire

@@ design/srr_stream_if.sv @@
// Valid/ready channel interfaces for the input, output and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface srr_in_if;
	logic valid;
	logic ready;
	logic [47:0] guess_a;
	logic [47:0] guess_b;
	modport source(output valid, guess_a, guess_b, input ready);
	modport sink(input valid, guess_a, guess_b, output ready);
endinterface

interface srr_out_if;
	logic valid;
	logic ready;
	logic [47:0] root;
	logic [1:0] status;
	logic [10:0] steps_taken;
	modport source(output valid, root, status, steps_taken, input ready);
	modport sink(input valid, root, status, steps_taken, output ready);
endinterface

interface srr_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [47:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/srr_datapath.sv @@
// Datapath: point registers, shared multiplier and shared bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none
module srr_datapath
	import srr_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire srr_cmd_t cmd,
	output srr_stat_t stat,
	input wire logic [DW-1:0] guess_a,
	input wire logic [DW-1:0] guess_b,
	input wire logic [DW-1:0] coef_q [5],
	input wire logic [TOL_W-1:0] tol_q,
	output logic [DW-1:0] x2_out,
	output logic [DW-1:0] x3_out
);
	localparam int unsigned PW = 2 * DW;
	localparam int unsigned HW = DW / 2;
	localparam int unsigned EW = DW + 1;
	localparam int unsigned CW = $clog2(PW + 1);
	localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [5:0] {
		U_IDLE = 6'b000001,
		U_MSET = 6'b000010,
		U_MUL = 6'b000100,
		U_ADD = 6'b001000,
		U_DIV = 6'b010000,
		U_QUO = 6'b100000
	} unit_t;

	logic signed [DW-1:0] x1_q, x2_q, x3_q, f1_q, f2_q, f3_q, den_q, q_q, acc_q, px_q;
	srr_op_t op_q;
	unit_t u_q;
	logic [2:0] hk_q;
	logic [DW-1:0] ma_q, mb_q;
	logic [1:0] mcnt_q;
	logic dmul_q;
	logic [PW-1:0] prod_q;
	logic pneg_q;
	logic [PW-1:0] num_q;
	logic [DW:0] rem_q;
	logic [CW-1:0] dcnt_q;
	logic done_q;

	// Magnitudes of operands.
	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
		mag = v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b, input logic sub);
		logic [DW:0] s;
		s = sub ? ({a[DW-1], a} - {b[DW-1], b}) : ({a[DW-1], a} + {b[DW-1], b});
		if (s[DW] != s[DW-1]) sat_add = s[DW] ? VMIN : VMAX;
		else sat_add = s[DW-1:0];
	endfunction

	// Saturated signed value from a sign and a wide magnitude.
	function automatic logic signed [DW-1:0] from_mag(input logic neg, input logic [PW-1:0] m);
		if (neg) from_mag = (m > PW'({1'b1, {(DW-1){1'b0}}})) ? VMIN : DW'(-m[DW-1:0]);
		else from_mag = (m > PW'(VMAX)) ? VMAX : m[DW-1:0];
	endfunction

	logic [PW-1:0] prod_shr;
	logic [DW:0] rem_sh;
	logic [DW-1:0] dmag;
	logic [EW-1:0] diff_w;
	logic [EW-1:0] dabs;
	logic [HW-1:0] mul_a, mul_b;
	logic [DW-1:0] mul_p;
	logic [PW-1:0] mul_term;
	logic [PW-1:0] prod_sum;
	logic signed [DW-1:0] hsum;
	assign prod_shr = prod_q >> FRAC_BITS;
	assign dmag = mag(den_q);
	assign rem_sh = {rem_q[DW-1:0], num_q[PW-1]};
	assign diff_w = {x3_q[DW-1], x3_q} - {x2_q[DW-1], x2_q};
	assign dabs = diff_w[DW] ? EW'(-diff_w) : diff_w;
	assign prod_sum = prod_q + mul_term;
	assign hsum = sat_add(from_mag(pneg_q, prod_shr), coef_q[hk_q], 1'b0);

	// One partial product of half-width operands per pass, placed at its weight.
	always_comb begin
		mul_a = mcnt_q[0] ? ma_q[DW-1:HW] : ma_q[HW-1:0];
		mul_b = mcnt_q[1] ? mb_q[DW-1:HW] : mb_q[HW-1:0];
		mul_p = DW'(mul_a) * DW'(mul_b);
		case (mcnt_q)
			2'd0: mul_term = PW'(mul_p);
			2'd1, 2'd2: mul_term = PW'(mul_p) << HW;
			default: mul_term = PW'(mul_p) << DW;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q <= U_IDLE;
			done_q <= 1'b0;
			op_q <= OP_NONE;
			hk_q <= '0;
			dcnt_q <= '0;
			x1_q <= '0;
			x2_q <= '0;
			x3_q <= '0;
			f1_q <= '0;
			f2_q <= '0;
			f3_q <= '0;
			den_q <= '0;
			q_q <= '0;
			acc_q <= '0;
			px_q <= '0;
			ma_q <= '0;
			mb_q <= '0;
			mcnt_q <= '0;
			dmul_q <= 1'b0;
			prod_q <= '0;
			pneg_q <= 1'b0;
			num_q <= '0;
			rem_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q <= cmd.op;
				case (cmd.op)
					OP_LOAD: begin
						x1_q <= guess_a;
						x2_q <= guess_b;
						done_q <= 1'b1;
					end
					OP_POLY_X1, OP_POLY_X2, OP_POLY_X3: begin
						acc_q <= coef_q[0];
						hk_q <= 3'd1;
						px_q <= (cmd.op == OP_POLY_X1) ? x1_q :
							(cmd.op == OP_POLY_X2) ? x2_q : x3_q;
						dmul_q <= 1'b0;
						u_q <= U_MSET;
					end
					OP_DEN: begin
						den_q <= sat_add(f2_q, f1_q, 1'b1);
						done_q <= 1'b1;
					end
					OP_DIV: begin
						px_q <= sat_add(x2_q, x1_q, 1'b1);
						dmul_q <= 1'b1;
						u_q <= U_MSET;
					end
					OP_X3: begin
						x3_q <= sat_add(x2_q, q_q, 1'b1);
						done_q <= 1'b1;
					end
					OP_SHIFT: begin
						x1_q <= x2_q;
						x2_q <= x3_q;
						done_q <= 1'b1;
					end
					default: done_q <= 1'b1;
				endcase
			end else begin
				case (u_q)
					// Operand magnitudes and product sign.
					U_MSET: begin
						ma_q <= mag(dmul_q ? f2_q : acc_q);
						mb_q <= mag(px_q);
						pneg_q <= dmul_q ? (f2_q[DW-1] ^ px_q[DW-1] ^ den_q[DW-1]) :
							(acc_q[DW-1] ^ px_q[DW-1]);
						prod_q <= '0;
						mcnt_q <= '0;
						u_q <= U_MUL;
					end
					// Four passes accumulate the full product.
					U_MUL: begin
						prod_q <= prod_sum;
						mcnt_q <= mcnt_q + 2'd1;
						if (mcnt_q == 2'd3) begin
							if (dmul_q) begin
								num_q <= prod_sum;
								rem_q <= '0;
								dcnt_q <= CW'(PW);
								u_q <= U_DIV;
							end else begin
								u_q <= U_ADD;
							end
						end
					end
					// Horner step: add the next coefficient.
					U_ADD: begin
						if (hk_q == 3'd4) begin
							u_q <= U_IDLE;
							done_q <= 1'b1;
							case (op_q)
								OP_POLY_X1: f1_q <= hsum;
								OP_POLY_X2: f2_q <= hsum;
								default: f3_q <= hsum;
							endcase
						end else begin
							acc_q <= hsum;
							hk_q <= hk_q + 3'd1;
							u_q <= U_MSET;
						end
					end
					// Restoring division, one quotient bit per cycle.
					U_DIV: begin
						if (rem_sh >= {1'b0, dmag}) begin
							rem_q <= rem_sh - {1'b0, dmag};
							num_q <= {num_q[PW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							num_q <= {num_q[PW-2:0], 1'b0};
						end
						dcnt_q <= dcnt_q - CW'(1);
						if (dcnt_q == CW'(1)) u_q <= U_QUO;
					end
					// Signed and saturated quotient.
					U_QUO: begin
						q_q <= from_mag(pneg_q, num_q);
						done_q <= 1'b1;
						u_q <= U_IDLE;
					end
					default: u_q <= U_IDLE;
				endcase
			end
		end
	end

	assign stat.done = done_q;
	assign stat.den_zero = (den_q == '0);
	assign stat.f3_zero = (f3_q == '0);
	assign stat.within_tol = (dabs <= EW'(tol_q));
	assign x2_out = x2_q;
	assign x3_out = x3_q;
endmodule
`default_nettype wire

@@ design/srr_ctrl.sv @@
// Controller state machine sequencing the secant iterations.
`timescale 1ns / 1ps
`default_nettype none
module srr_ctrl
	import srr_pkg::*;
#(
	parameter int unsigned MAX_ITER = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	output logic busy,
	output logic res_valid,
	input wire logic res_take,
	output srr_cmd_t cmd,
	input wire srr_stat_t stat,
	input wire logic [DW-1:0] x2_cur,
	input wire logic [DW-1:0] x3_cur,
	output logic [DW-1:0] res_root,
	output logic [1:0] res_status,
	output logic [STEPS_W-1:0] res_steps
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_F1 = 9'b000000010,
		S_F2 = 9'b000000100,
		S_DEN = 9'b000001000,
		S_DIV = 9'b000010000,
		S_X3 = 9'b000100000,
		S_F3 = 9'b001000000,
		S_SHIFT = 9'b010000000,
		S_LOAD = 9'b100000000
	} state_t;

	state_t st_q;
	logic wait_q;
	logic [STEPS_W-1:0] steps_q;
	logic res_valid_q;
	logic [DW-1:0] res_root_q;
	logic [1:0] res_status_q;
	logic [STEPS_W-1:0] res_steps_q;

	// Command issue; a step that can end the item holds while a result still waits.
	always_comb begin
		cmd.start = 1'b0;
		cmd.op = OP_NONE;
		if (!wait_q) begin
			cmd.start = !((st_q inside {S_DEN, S_F3}) && res_valid_q);
			case (st_q)
				S_IDLE: begin
					cmd.start = in_fire;
					cmd.op = OP_LOAD;
				end
				S_LOAD: cmd.op = OP_LOAD;
				S_F1: cmd.op = OP_POLY_X1;
				S_F2: cmd.op = OP_POLY_X2;
				S_DEN: cmd.op = OP_DEN;
				S_DIV: cmd.op = OP_DIV;
				S_X3: cmd.op = OP_X3;
				S_F3: cmd.op = OP_POLY_X3;
				S_SHIFT: cmd.op = OP_SHIFT;
				default: cmd.op = OP_NONE;
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res_root = res_root_q;
	assign res_status = res_status_q;
	assign res_steps = res_steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			wait_q <= 1'b0;
			steps_q <= '0;
			res_valid_q <= 1'b0;
			res_root_q <= '0;
			res_status_q <= '0;
			res_steps_q <= '0;
		end else begin
			if (res_take) res_valid_q <= 1'b0;
			if (cmd.start) wait_q <= 1'b1;
			case (st_q)
				S_IDLE: if (in_fire) begin
					st_q <= S_LOAD;
					steps_q <= '0;
				end
				default: if (wait_q && stat.done) begin
					wait_q <= 1'b0;
					case (st_q)
						S_LOAD: st_q <= S_F1;
						S_F1: st_q <= S_F2;
						S_F2: st_q <= S_DEN;
						S_DEN: if (stat.den_zero) begin
							res_root_q <= x2_cur;
							res_status_q <= ST_ZERO_DEN;
							res_steps_q <= steps_q;
							res_valid_q <= 1'b1;
							st_q <= S_IDLE;
						end else st_q <= S_DIV;
						S_DIV: st_q <= S_X3;
						S_X3: begin
							steps_q <= steps_q + STEPS_W'(1);
							st_q <= S_F3;
						end
						S_F3: begin
							res_root_q <= x3_cur;
							res_steps_q <= steps_q;
							if (stat.f3_zero) begin
								res_status_q <= ST_EXACT;
								res_valid_q <= 1'b1;
								st_q <= S_IDLE;
							end else if (stat.within_tol) begin
								res_status_q <= ST_TOL;
								res_valid_q <= 1'b1;
								st_q <= S_IDLE;
							end else if (steps_q == STEPS_W'(MAX_ITER)) begin
								res_status_q <= ST_LIMIT;
								res_valid_q <= 1'b1;
								st_q <= S_IDLE;
							end else st_q <= S_SHIFT;
						end
						S_SHIFT: st_q <= S_F1;
						default: st_q <= S_IDLE;
					endcase
				end
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/secant_root_refine_unit.sv @@
// Top level of the secant root refinement unit.
//  channel   | role   | payload
//  guess_ch  | sink   | guess_a, guess_b
//  result_ch | source | root, status, steps_taken
//  cfg_ch    | sink   | index, data
// A secant step takes three Horner evaluations, each product built in four passes of a
// 24 by 24 bit multiplier, a quotient from the restoring divider, and three register steps.
// An item runs at most MAX_ITER secant steps. Reset is asynchronous and restores the
// register defaults. One item is in flight at a time; a new one is accepted while the
// previous result waits, but a step that can end it stalls until that is taken.
`timescale 1ns / 1ps
`default_nettype none
module secant_root_refine_unit
	import srr_pkg::*;
#(
	parameter int unsigned MAX_ITER = 64,
	parameter int unsigned FRAC_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	srr_in_if.sink guess_ch,
	srr_out_if.source result_ch,
	srr_cfg_if.sink cfg_ch
);
	logic [DW-1:0] coef_q [5];
	logic [TOL_W-1:0] tol_q;
	srr_cmd_t cmd;
	srr_stat_t stat;
	logic busy, res_valid;
	logic [DW-1:0] x2_cur;
	logic [DW-1:0] x3_cur;

	// Configuration register file.
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) coef_q[i] <= '0;
			tol_q <= TOL_W'(TOL_RESET);
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_COEF_X4, REG_COEF_X3, REG_COEF_X2, REG_COEF_X1, REG_COEF_X0:
					coef_q[cfg_ch.index] <= cfg_ch.data;
				REG_TOLERANCE: tol_q <= cfg_ch.data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign guess_ch.ready = !busy;
	assign result_ch.valid = res_valid;

	srr_ctrl #(.MAX_ITER(MAX_ITER)) u_ctrl (
		.clk, .arst_n,
		.in_fire(guess_ch.valid && guess_ch.ready),
		.busy, .res_valid,
		.res_take(result_ch.valid && result_ch.ready),
		.cmd, .stat, .x2_cur, .x3_cur,
		.res_root(result_ch.root),
		.res_status(result_ch.status),
		.res_steps(result_ch.steps_taken)
	);

	srr_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.guess_a(guess_ch.guess_a), .guess_b(guess_ch.guess_b),
		.coef_q, .tol_q, .x2_out(x2_cur), .x3_out(x3_cur)
	);
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the secant root refinement unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench
	import srr_pkg::*;
();
	localparam longint VMAX = 64'sd140737488355327;
	localparam longint VMIN = -64'sd140737488355328;
	localparam int MAX_STEPS = 64;
	localparam int FRAC = 24;

	typedef struct packed {
		logic [47:0] a;
		logic [47:0] b;
	} guess_pair_t;

	typedef struct packed {
		logic [47:0] root;
		logic [1:0] status;
		logic [10:0] steps;
	} root_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	srr_in_if guess_ch();
	srr_out_if result_ch();
	srr_cfg_if cfg_ch();

	secant_root_refine_unit u_top(
		.clk(clk),
		.arst_n(arst_n),
		.guess_ch(guess_ch),
		.result_ch(result_ch),
		.cfg_ch(cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor copy of the registers.
	longint coef_m [5];
	longint tol_m;

	guess_pair_t pending_pairs [$];
	root_answer_t expected_answers [$];
	int mismatch_count = 0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;

	// Configuration writes requested by the stimulus.
	logic cfg_req = 1'b0;
	logic [2:0] cfg_idx_req;
	logic [47:0] cfg_data_req;
	logic cfg_done = 1'b0;

	function automatic longint clamp48(input longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	function automatic longint sat_from_mag(input bit neg, input logic [127:0] m);
		if (neg) begin
			if (m > 128'd140737488355328) return VMIN;
			return -longint'(m[63:0]);
		end
		if (m > 128'd140737488355327) return VMAX;
		return longint'(m[63:0]);
	endfunction

	function automatic logic [127:0] mag128(input longint v);
		logic [127:0] r;
		r = v < 0 ? 128'(-v) : 128'(v);
		return r;
	endfunction

	function automatic longint fixed_mul(input longint a, input longint b);
		logic [127:0] p;
		p = (mag128(a) * mag128(b)) >> FRAC;
		return sat_from_mag((a < 0) != (b < 0), p);
	endfunction

	function automatic longint fixed_muldiv(input longint n, input longint m, input longint d);
		logic [127:0] q;
		q = (mag128(n) * mag128(m)) / mag128(d);
		return sat_from_mag(((n < 0) != (m < 0)) != (d < 0), q);
	endfunction

	function automatic longint eval_quartic(input longint x);
		longint acc;
		acc = coef_m[0];
		for (int k = 1; k < 5; k++)
			acc = clamp48(fixed_mul(acc, x) + coef_m[k]);
		return acc;
	endfunction

	// Runs the secant iteration on one pair of guesses.
	function automatic root_answer_t refine_root(input guess_pair_t g);
		longint x1, x2, x3, f1, f2, den, d;
		root_answer_t r;
		x1 = longint'(signed'(g.a));
		x2 = longint'(signed'(g.b));
		r.root = g.b;
		r.status = ST_LIMIT;
		r.steps = '0;
		for (int it = 0; it < MAX_STEPS; it++) begin
			f1 = eval_quartic(x1);
			f2 = eval_quartic(x2);
			den = clamp48(f2 - f1);
			if (den == 0) begin
				r.status = ST_ZERO_DEN;
				r.root = x2[47:0];
				break;
			end
			x3 = clamp48(x2 - fixed_muldiv(f2, clamp48(x2 - x1), den));
			r.steps++;
			r.root = x3[47:0];
			if (eval_quartic(x3) == 0) begin
				r.status = ST_EXACT;
				break;
			end
			d = x3 - x2;
			if (d < 0) d = -d;
			if (d <= tol_m) begin
				r.status = ST_TOL;
				break;
			end
			x1 = x2;
			x2 = x3;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Driver for the input and configuration channels.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guess_ch.valid <= 1'b0;
			guess_ch.guess_a <= '0;
			guess_ch.guess_b <= '0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= '0;
			cfg_ch.data <= '0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				cfg_ch.valid <= 1'b0;
				cfg_done <= 1'b1;
			end else if (cfg_req && !cfg_ch.valid && !cfg_done) begin
				cfg_ch.valid <= 1'b1;
				cfg_ch.index <= cfg_idx_req;
				cfg_ch.data <= cfg_data_req;
			end
			if (!guess_ch.valid || guess_ch.ready) begin
				if (guess_ch.valid) expected_answers.insert(expected_answers.size(),
					refine_root({guess_ch.guess_a, guess_ch.guess_b}));
				if (pending_pairs.size() > 0 &&
						$urandom_range(99) >= in_idle_pct) begin
					guess_pair_t g;
					g = pending_pairs.pop_front();
					guess_ch.valid <= 1'b1;
					guess_ch.guess_a <= g.a;
					guess_ch.guess_b <= g.b;
				end else begin
					guess_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and ready generation for the result channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("unexpected transaction", result_ch.root, '0);
				end else begin
					root_answer_t e;
					e = expected_answers.pop_front();
					if (result_ch.root !== e.root)
						report_mismatch("root", result_ch.root, e.root);
					if (result_ch.status !== e.status)
						report_mismatch("status", 48'(result_ch.status), 48'(e.status));
					if (result_ch.steps_taken !== e.steps)
						report_mismatch("steps_taken", 48'(result_ch.steps_taken),
							48'(e.steps));
				end
			end
			result_ch.ready <= $urandom_range(99) >= out_stall_pct;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		cfg_idx_req = idx;
		cfg_data_req = val;
		cfg_req = 1'b1;
		wait (cfg_done);
		@(negedge clk);
		cfg_req = 1'b0;
		cfg_done = 1'b0;
		if (idx == REG_TOLERANCE) tol_m = longint'(val[24:0]);
		else coef_m[idx] = longint'(signed'(val));
	endtask

	// Waits until every queued pair has produced its answer; sampled on settled values.
	task automatic drain;
		while (!(pending_pairs.size() == 0 && !guess_ch.valid &&
				expected_answers.size() == 0))
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic push_pair(input longint a, input longint b);
		guess_pair_t g;
		g.a = a[47:0];
		g.b = b[47:0];
		pending_pairs.insert(pending_pairs.size(), g);
	endtask

	function automatic longint rand48;
		return longint'(signed'({$urandom(), $urandom()} >> 16));
	endfunction

	function automatic longint rand_small(input int lim);
		return (longint'($urandom_range(2 * lim)) - lim) <<< FRAC;
	endfunction

	// Loads one polynomial setting into the five coefficient registers.
	task automatic load_poly(input longint c4, c3, c2, c1, c0);
		write_reg(REG_COEF_X4, c4[47:0]);
		write_reg(REG_COEF_X3, c3[47:0]);
		write_reg(REG_COEF_X2, c2[47:0]);
		write_reg(REG_COEF_X1, c1[47:0]);
		write_reg(REG_COEF_X0, c0[47:0]);
	endtask

	initial begin
		longint one;
		one = 64'sd1 <<< FRAC;
		for (int k = 0; k < 5; k++) coef_m[k] = 0;
		tol_m = 168;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		in_idle_pct = 23;
		out_stall_pct = 80;

		// Reset polynomial is zero: every first denominator is zero.
		push_pair(one, 2 * one);
		drain();

		// x^2 - 2 with default tolerance, then equal guesses and extremes.
		load_poly(0, 0, one, 0, -2 * one);
		push_pair(one, 2 * one);
		push_pair(3 * one, 3 * one);
		push_pair(-one, one);
		push_pair(VMIN, VMAX);
		push_pair(VMAX, VMIN);
		push_pair(0, -1);
		push_pair(-5 * one, -4 * one);
		drain();

		// Extreme tolerances and extreme coefficients.
		write_reg(REG_TOLERANCE, 48'h1FFFFFF);
		push_pair(one, 2 * one);
		push_pair(10 * one, 11 * one);
		drain();
		write_reg(REG_TOLERANCE, 48'd0);
		push_pair(one, 2 * one);
		push_pair(-one, -2 * one);
		drain();
		load_poly(VMAX, VMIN, VMAX, VMIN, VMAX);
		push_pair(one, -one);
		push_pair(VMAX, 0);
		drain();
		load_poly(VMIN, VMAX, 0, -1, VMIN);
		push_pair(VMIN, one);
		push_pair(one >>> 3, -(one >>> 5));
		drain();
		// Linear with a slope that lands exactly on zero.
		load_poly(0, 0, 0, one, -3 * one);
		write_reg(REG_TOLERANCE, 48'd16777216);
		push_pair(0, one);
		push_pair(7 * one, one);
		drain();

		// Random part in three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			in_idle_pct = ph == 0 ? 23 : (ph == 1 ? 80 : 0);
			out_stall_pct = ph == 0 ? 80 : (ph == 1 ? 23 : 0);
			for (int s = 0; s < 4; s++) begin
				if ($urandom_range(3) == 0)
					load_poly(rand48(), rand48(), rand48(), rand48(), rand48());
				else
					load_poly(rand_small(2), rand_small(3), rand_small(6),
						rand_small(9), rand_small(9));
				write_reg(REG_TOLERANCE, 48'($urandom_range(1 << 12)));
				for (int i = 0; i < 10; i++) begin
					if ($urandom_range(9) == 0) push_pair(rand48(), rand48());
					else push_pair(rand_small(4) + $urandom_range(1 << 20),
						rand_small(4) - $urandom_range(1 << 20));
				end
				drain();
			end
		end

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#200_000_000;
		$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
